// ----- rtl/gfau_pkg.sv -----
// GF(2^8) arithmetic unit package: field constants, command codes, result selects
// and the elaboration-time builders for the exp and log ROM contents.
// No dependencies.
package gfau_pkg;

    localparam logic [8:0] FIELD_POLY  = 9'h187;
    localparam logic [8:0] FIELD_ORDER = 9'd255;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_MUL = 3'd0;
    localparam cmd_t CMD_DIV = 3'd1;
    localparam cmd_t CMD_INV = 3'd2;
    localparam cmd_t CMD_EXP = 3'd3;
    localparam cmd_t CMD_LOG = 3'd4;

    typedef logic [1:0] rsel_t;
    localparam rsel_t RSEL_EXP  = 2'd0;
    localparam rsel_t RSEL_LOG  = 2'd1;
    localparam rsel_t RSEL_ZERO = 2'd2;

    typedef logic [7:0] rom_t [256];

    typedef struct packed {
        cmd_t  cmd;
        rsel_t rsel;
    } op_ctrl_t;

    function automatic rom_t exp_table();
        rom_t       t;
        logic [8:0] x;
        t = '{default: 8'd0};
        x = 9'd1;
        for (int i = 0; i < int'(FIELD_ORDER); i++) begin
            t[8'(i)] = x[7:0];
            x = {x[7:0], 1'b0};
            if (x[8]) begin
                x = x ^ FIELD_POLY;
            end
        end
        t[255] = 8'd1;
        return t;
    endfunction

    function automatic rom_t log_table();
        rom_t       t;
        logic [8:0] x;
        t = '{default: 8'd0};
        x = 9'd1;
        for (int i = 0; i < int'(FIELD_ORDER); i++) begin
            t[x[7:0]] = 8'(i);
            x = {x[7:0], 1'b0};
            if (x[8]) begin
                x = x ^ FIELD_POLY;
            end
        end
        t[0] = 8'd0;
        return t;
    endfunction

endpackage

// ----- rtl/gf256_arithmetic_unit_top.sv -----
// GF(2^8) arithmetic unit top level, field polynomial 0x187, generator 2.
// Uses gfau_pkg, gfau_log_rom and gfau_exp_rom.
//
// Input stream s_*: one command per transfer (multiply, divide, inverse,
// exponentiate, logarithm) with two byte operands and a signed exponent.
// Output stream m_*: one result byte per input transfer, in order.
// Pipeline: log ROM read and exponent fold, log add/subtract modulo 255,
// exp ROM read, output register; a result reaches m_tvalid once it has
// passed each registered stage in order. Unless m_tready stalls the output,
// throughput is one transfer per cycle; the two log ROM ports, the exp ROM
// and the two modulo-255 adders each serve one item per cycle.
// Each stage moves forward when the stage after it is empty or moving, so
// bubbles are squeezed out and s_tready stays high while any stage is free.
// When m_tready is low the pipeline fills; s_tready drops only once all four
// stages hold an item, and the held result stays on m_tdata.
// Reset (aresetn low, synchronous) empties the pipeline; the ROMs are
// fixed contents and need no initialization.
module gf256_arithmetic_unit_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cmd[2:0], operand_a[10:3], operand_b[18:11], exponent[34:19] (signed), zero fill
    input  logic [gfau_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // value[7:0]
    output logic [gfau_pkg::M_TDATA_W-1:0] m_tdata
);
    import gfau_pkg::*;

    cmd_t        in_cmd;
    logic [7:0]  in_a;
    logic [7:0]  in_b;
    logic [15:0] in_exp;

    logic v1_reg, v2_reg, v3_reg, mv_reg;
    logic en1, en2, en3, out_en;

    op_ctrl_t   ctrl_next, ctrl1_reg;
    logic [7:0] emod_next, emod1_reg;
    logic [9:0] efold0;
    logic [8:0] efold1;

    logic [7:0] la1, lb1;

    logic [8:0] sum_x, sum_y, sum_xy;
    logic [7:0] addr_next, addr2_reg;
    rsel_t      rsel2_reg, rsel3_reg;
    logic [7:0] la2_reg, la3_reg;

    logic [7:0] exp_q;
    logic [7:0] m_tdata_next, m_tdata_reg;

    assign in_cmd = s_tdata[2:0];
    assign in_a   = s_tdata[10:3];
    assign in_b   = s_tdata[18:11];
    assign in_exp = s_tdata[34:19];

    assign out_en   = !mv_reg || m_tready;
    assign en3      = !v3_reg || out_en;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // stage 1: decode, exponent fold modulo 255 (2^8 = 1 mod 255)
    always_comb begin
        ctrl_next.cmd  = in_cmd;
        ctrl_next.rsel = RSEL_ZERO;
        unique case (in_cmd)
            CMD_MUL, CMD_DIV: ctrl_next.rsel = (in_a != 8'd0 && in_b != 8'd0) ? RSEL_EXP
                                                                               : RSEL_ZERO;
            CMD_INV:          ctrl_next.rsel = (in_a != 8'd0) ? RSEL_EXP : RSEL_ZERO;
            CMD_EXP:          ctrl_next.rsel = RSEL_EXP;
            CMD_LOG:          ctrl_next.rsel = RSEL_LOG;
            default:          ctrl_next.rsel = RSEL_ZERO;
        endcase
    end

    always_comb begin
        efold0 = {2'b00, in_exp[15:8]} + {2'b00, in_exp[7:0]} + {1'b0, FIELD_ORDER}
                 - {9'd0, in_exp[15]};
        efold1 = {7'd0, efold0[9:8]} + {1'b0, efold0[7:0]};
        emod_next = (efold1 >= FIELD_ORDER) ? 8'(efold1 - FIELD_ORDER) : efold1[7:0];
    end

    gfau_log_rom u_log_rom (
        .aclk   (aclk),
        .en     (en1),
        .addr_a (in_a),
        .addr_b (in_b),
        .data_a (la1),
        .data_b (lb1)
    );

    always_ff @(posedge aclk) begin
        if (en1) begin
            ctrl1_reg <= ctrl_next;
            emod1_reg <= emod_next;
        end
    end

    // stage 2: exp ROM address, sum of logs or folded exponent modulo 255
    always_comb begin
        sum_x = 9'd0;
        sum_y = 9'd0;
        unique case (ctrl1_reg.cmd)
            CMD_MUL: begin
                sum_x = {1'b0, la1};
                sum_y = {1'b0, lb1};
            end
            CMD_DIV: begin
                sum_x = {1'b0, la1};
                sum_y = FIELD_ORDER - {1'b0, lb1};
            end
            CMD_INV: begin
                sum_x = 9'd0;
                sum_y = FIELD_ORDER - {1'b0, la1};
            end
            CMD_EXP: begin
                sum_x = {1'b0, emod1_reg};
                sum_y = 9'd0;
            end
            default: begin
                sum_x = 9'd0;
                sum_y = 9'd0;
            end
        endcase
        sum_xy    = sum_x + sum_y;
        addr_next = (sum_xy >= FIELD_ORDER) ? 8'(sum_xy - FIELD_ORDER) : sum_xy[7:0];
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            addr2_reg <= addr_next;
            rsel2_reg <= ctrl1_reg.rsel;
            la2_reg   <= la1;
        end
    end

    // stage 3: exp ROM read
    gfau_exp_rom u_exp_rom (
        .aclk (aclk),
        .en   (en3),
        .addr (addr2_reg),
        .data (exp_q)
    );

    always_ff @(posedge aclk) begin
        if (en3) begin
            rsel3_reg <= rsel2_reg;
            la3_reg   <= la2_reg;
        end
    end

    // output register
    always_comb begin
        unique case (rsel3_reg)
            RSEL_EXP: m_tdata_next = exp_q;
            RSEL_LOG: m_tdata_next = la3_reg;
            default:  m_tdata_next = 8'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_tvalid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (out_en) begin
                mv_reg <= v3_reg;
            end
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_ready_low_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && mv_reg))
        else $error("s_tready low with a free pipeline stage");

    a_reset_empties_pipe: assert property (@(posedge aclk)
        !aresetn |=> !(v1_reg || v2_reg || v3_reg || mv_reg))
        else $error("pipeline not empty after reset");

    a_exp_addr_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (addr2_reg != 8'hff))
        else $error("exp ROM address not reduced modulo 255");

    a_exp_result_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && rsel3_reg == RSEL_EXP) |-> (exp_q != 8'h00))
        else $error("exp ROM read returned zero for a field result");
`endif

endmodule

// ----- rtl/gfau_log_rom.sv -----
// Dual-port log ROM with registered read data.
// Depends on gfau_pkg for the table builder.
module gfau_log_rom (
    input  logic       aclk,
    input  logic       en,
    input  logic [7:0] addr_a,
    input  logic [7:0] addr_b,
    output logic [7:0] data_a,
    output logic [7:0] data_b
);
    import gfau_pkg::*;

    localparam rom_t LOG_ROM = log_table();

    logic [7:0] data_a_reg;
    logic [7:0] data_b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            data_a_reg <= LOG_ROM[addr_a];
            data_b_reg <= LOG_ROM[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

// ----- rtl/gfau_exp_rom.sv -----
// Single-port exp (antilog) ROM with registered read data.
// Depends on gfau_pkg for the table builder.
module gfau_exp_rom (
    input  logic       aclk,
    input  logic       en,
    input  logic [7:0] addr,
    output logic [7:0] data
);
    import gfau_pkg::*;

    localparam rom_t EXP_ROM = exp_table();

    logic [7:0] data_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= EXP_ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

// ----- verif/tb_gf256_arithmetic_unit_top.sv -----
// Self-checking testbench for gf256_arithmetic_unit_top: directed and random field operations
// checked against an in-bench GF(2^8) predictor. Depends on rtl/gfau_pkg.sv and the RTL.
module tb_gf256_arithmetic_unit_top;

    import gfau_pkg::*;

    localparam int GF_ORDER   = int'(FIELD_ORDER);
    localparam int CMD_MAX    = 2**$bits(cmd_t) - 1;
    localparam int N_RANDOM   = 1750;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 12;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_RARELY,
        RDY_PULSED
    } rdy_mode_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [7:0]           alpha_pow [256];
    logic [7:0]           alpha_log [256];

    logic [S_TDATA_W-1:0] pending_ops [$];
    logic [7:0]           expected_values [$];
    int                   errors = 0;
    int                   idle_cycles = 0;
    int                   burst_left = 0;
    int                   gap_left = 0;
    rdy_mode_t            rdy_mode = RDY_ALWAYS;
    int                   mode_left = 0;
    int                   pulse_cnt = 0;

    gf256_arithmetic_unit_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic logic [S_TDATA_W-1:0] pack_op(cmd_t c, logic [7:0] a, logic [7:0] b,
                                                     logic [15:0] e);
        return {{(S_TDATA_W - 35){1'b0}}, e, b, a, c};
    endfunction

    function automatic logic [7:0] gf_predict(logic [S_TDATA_W-1:0] word);
        cmd_t       c;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] r;
        int         la;
        int         lb;
        int         m;
        c  = word[2:0];
        a  = word[10:3];
        b  = word[18:11];
        la = int'(alpha_log[a]);
        lb = int'(alpha_log[b]);
        r  = '0;
        case (c)
            CMD_MUL: if (a != 0 && b != 0) r = alpha_pow[8'((la + lb) % GF_ORDER)];
            CMD_DIV: if (a != 0 && b != 0) r = alpha_pow[8'((la + GF_ORDER - lb) % GF_ORDER)];
            CMD_INV: if (a != 0) r = alpha_pow[8'((GF_ORDER - la) % GF_ORDER)];
            CMD_EXP: begin
                m = int'($signed(word[34:19])) % GF_ORDER;
                if (m < 0) m += GF_ORDER;
                r = alpha_pow[8'(m)];
            end
            CMD_LOG: r = alpha_log[a];
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] rand_elem();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h01;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_exponent();
        case ($urandom_range(0, 7))
            0, 1:    return 16'($signed($urandom_range(0, 1200)) - 600);
            2:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            3:       return 16'(GF_ORDER * $urandom_range(0, 128));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        errors++;
    endtask

    // sender: bursts of random length separated by random, possibly empty, gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0 || pending_ops.size() == 0) begin
                s_tvalid <= 1'b0;
                if (gap_left != 0) gap_left <= gap_left - 1;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_ops.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver: backpressure pattern switches to a random mode at random intervals
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            rdy_mode  <= rdy_mode_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(64, 512);
            pulse_cnt <= 0;
        end else begin
            mode_left <= mode_left - 1;
            pulse_cnt <= pulse_cnt + 1;
        end
        case (rdy_mode)
            RDY_ALWAYS: m_tready <= 1'b1;
            RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            RDY_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
            default:    m_tready <= (pulse_cnt % 11) < 4;
        endcase
    end

    always @(posedge aclk) begin
        logic [7:0] want;
        if (aresetn) begin
            if (s_tvalid && s_tready) expected_values.push_back(gf_predict(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_values.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value=%02h", m_tdata));
                end else begin
                    want = expected_values.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("value got %02h expected %02h",
                                                  m_tdata, want));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_gf256_arithmetic_unit_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [7:0] x;
        cmd_t       c;

        x = 8'd1;
        alpha_log[0] = 8'd0;
        for (int k = 0; k < GF_ORDER; k++) begin
            alpha_pow[8'(k)] = x;
            alpha_log[x] = 8'(k);
            x = {x[6:0], 1'b0} ^ (x[7] ? FIELD_POLY[7:0] : 8'h00);
        end
        alpha_pow[8'(GF_ORDER)] = 8'd1;

        // zero operands, identity, top of the field
        pending_ops.push_back(pack_op(CMD_MUL, 8'h00, 8'h5a, 16'h1234));
        pending_ops.push_back(pack_op(CMD_MUL, 8'hc3, 8'h00, 16'hedcb));
        pending_ops.push_back(pack_op(CMD_MUL, 8'h01, 8'h01, 16'h0000));
        pending_ops.push_back(pack_op(CMD_MUL, 8'hff, 8'hff, 16'hffff));
        pending_ops.push_back(pack_op(CMD_DIV, 8'h37, 8'h00, 16'h0000));
        pending_ops.push_back(pack_op(CMD_DIV, 8'h00, 8'h37, 16'hffff));
        pending_ops.push_back(pack_op(CMD_DIV, 8'hff, 8'h01, 16'h8000));
        pending_ops.push_back(pack_op(CMD_DIV, 8'h01, 8'hff, 16'h7fff));
        pending_ops.push_back(pack_op(CMD_INV, 8'h00, 8'hff, 16'h0001));
        pending_ops.push_back(pack_op(CMD_INV, 8'h01, 8'h00, 16'h0000));
        pending_ops.push_back(pack_op(CMD_INV, 8'hff, 8'haa, 16'h5555));
        // exponent folding: zero, negative, wrap at the group order, 16-bit extremes
        pending_ops.push_back(pack_op(CMD_EXP, 8'hff, 8'hff, 16'h0000));
        pending_ops.push_back(pack_op(CMD_EXP, 8'h00, 8'h00, 16'hffff));
        pending_ops.push_back(pack_op(CMD_EXP, 8'h00, 8'h00, 16'd254));
        pending_ops.push_back(pack_op(CMD_EXP, 8'h00, 8'h00, 16'd255));
        pending_ops.push_back(pack_op(CMD_EXP, 8'h00, 8'h00, 16'h7fff));
        pending_ops.push_back(pack_op(CMD_EXP, 8'h00, 8'h00, 16'h8000));
        pending_ops.push_back(pack_op(CMD_EXP, 8'h00, 8'h00, -16'sd255));
        pending_ops.push_back(pack_op(CMD_LOG, 8'h00, 8'hff, 16'hffff));
        pending_ops.push_back(pack_op(CMD_LOG, 8'h01, 8'h00, 16'h0000));
        pending_ops.push_back(pack_op(CMD_LOG, 8'hff, 8'h00, 16'h0000));
        for (int k = int'(CMD_LOG) + 1; k <= CMD_MAX; k++)
            pending_ops.push_back(pack_op(cmd_t'(k), 8'hff, 8'h5a, 16'h0101));

        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 15) == 0)
                c = cmd_t'($urandom_range(int'(CMD_LOG) + 1, CMD_MAX));
            else
                c = cmd_t'($urandom_range(int'(CMD_MUL), int'(CMD_LOG)));
            pending_ops.push_back(pack_op(c, rand_elem(), rand_elem(), rand_exponent()));
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (pending_ops.size() != 0 || s_tvalid || expected_values.size() != 0);
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (errors == 0) begin
            $display("tb_gf256_arithmetic_unit_top: PASS");
        end else begin
            $display("tb_gf256_arithmetic_unit_top: FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/gfau_pkg.sv
rtl/gfau_log_rom.sv
rtl/gfau_exp_rom.sv
rtl/gf256_arithmetic_unit_top.sv
verif/tb_gf256_arithmetic_unit_top.sv
